FILE: design/cau_pkg.sv
// package with shared types, op codes and saturation helper for the complex arithmetic unit
`default_nettype none
package cau_pkg;

  localparam int DW = 32;
  localparam int QW = 32;
  localparam int NW = 64;
  localparam int CELLS = QW + 1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_NEG  = 3'd5,
    OP_ABS2 = 3'd6
  } op_t;

  typedef struct packed {
    logic          valid;
    logic          is_div;
    logic          dz;
    logic          sat_re;
    logic          sat_im;
    logic          neg_re;
    logic          neg_im;
    logic [NW-1:0] d;
    logic [NW-1:0] rem_re;
    logic [NW-1:0] rem_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic [DW-1:0] res_re;
    logic [DW-1:0] res_im;
    logic          ov;
  } lane_t;

  // returns {overflow, saturated value}
  function automatic logic [DW:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh7FFF_FFFF;
    lo = -66'sh8000_0000;
    if (v > hi) begin
      sat32 = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      sat32 = {1'b0, v[DW-1:0]};
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/cau_front.sv
// product stage and sum stage: non-divide results and divider setup
`default_nettype none
module cau_front import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [2:0]    in_op,
  input  wire logic [DW-1:0] in_a_re,
  input  wire logic [DW-1:0] in_a_im,
  input  wire logic [DW-1:0] in_b_re,
  input  wire logic [DW-1:0] in_b_im,
  output lane_t              lane_o
);

  logic                 v1_r;
  logic [2:0]           op1_r;
  logic signed [DW-1:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [63:0]   p_arbr_r, p_aibi_r, p_arbi_r, p_aibr_r, p_brbr_r, p_bibi_r;
  lane_t                lane_r;
  lane_t                lane_nxt;

  logic signed [DW-1:0] ar, ai, bru, biu;
  always_comb begin
    ar  = $signed(in_a_re);
    ai  = $signed(in_a_im);
    bru = (op_t'(in_op) == OP_ABS2) ? $signed(in_a_re) : $signed(in_b_re);
    biu = (op_t'(in_op) == OP_ABS2) ? $signed(in_a_im) : $signed(in_b_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      op1_r    <= in_op;
      ar1_r    <= ar;
      ai1_r    <= ai;
      br1_r    <= $signed(in_b_re);
      bi1_r    <= $signed(in_b_im);
      p_arbr_r <= 64'(ar) * 64'(bru);
      p_aibi_r <= 64'(ai) * 64'(biu);
      p_arbi_r <= 64'(ar) * 64'($signed(in_b_im));
      p_aibr_r <= 64'(ai) * 64'($signed(in_b_re));
      p_brbr_r <= 64'($signed(in_b_re)) * 64'($signed(in_b_re));
      p_bibi_r <= 64'($signed(in_b_im)) * 64'($signed(in_b_im));
    end
  end

  logic signed [65:0] t_arbr, t_aibi, t_arbi, t_aibr, t_brbr, t_bibi;
  logic signed [65:0] s_re, s_im, n_re, n_im, d_s;
  logic [DW:0]        sr, si;
  logic [65:0]        mag_re, mag_im;

  always_comb begin
    t_arbr = 66'(p_arbr_r >>> FRAC_BITS);
    t_aibi = 66'(p_aibi_r >>> FRAC_BITS);
    t_arbi = 66'(p_arbi_r >>> FRAC_BITS);
    t_aibr = 66'(p_aibr_r >>> FRAC_BITS);
    t_brbr = 66'(p_brbr_r >>> FRAC_BITS);
    t_bibi = 66'(p_bibi_r >>> FRAC_BITS);
    n_re   = t_arbr + t_aibi;
    n_im   = t_aibr - t_arbi;
    d_s    = t_brbr + t_bibi;
    s_re   = '0;
    s_im   = '0;
    case (op_t'(op1_r))
      OP_ADD: begin
        s_re = 66'(ar1_r) + 66'(br1_r);
        s_im = 66'(ai1_r) + 66'(bi1_r);
      end
      OP_SUB: begin
        s_re = 66'(ar1_r) - 66'(br1_r);
        s_im = 66'(ai1_r) - 66'(bi1_r);
      end
      OP_MUL: begin
        s_re = t_arbr - t_aibi;
        s_im = t_arbi + t_aibr;
      end
      OP_CONJ: begin
        s_re = 66'(ar1_r);
        s_im = -66'(ai1_r);
      end
      OP_NEG: begin
        s_re = -66'(ar1_r);
        s_im = -66'(ai1_r);
      end
      OP_ABS2: begin
        s_re = t_arbr + t_aibi;
        s_im = '0;
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    sr     = sat32(s_re);
    si     = sat32(s_im);
    mag_re = n_re[65] ? 66'(-n_re) : 66'(n_re);
    mag_im = n_im[65] ? 66'(-n_im) : 66'(n_im);

    lane_nxt        = '0;
    lane_nxt.valid  = v1_r;
    lane_nxt.is_div = (op_t'(op1_r) == OP_DIV);
    lane_nxt.d      = d_s[NW-1:0];
    lane_nxt.dz     = (d_s == '0);
    lane_nxt.neg_re = n_re[65];
    lane_nxt.neg_im = n_im[65];
    lane_nxt.rem_re = mag_re[NW-1:0] << FRAC_BITS;
    lane_nxt.rem_im = mag_im[NW-1:0] << FRAC_BITS;
    lane_nxt.res_re = sr[DW-1:0];
    lane_nxt.res_im = si[DW-1:0];
    lane_nxt.ov     = sr[DW] | si[DW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.is_div <= lane_nxt.is_div;
      lane_r.dz     <= lane_nxt.dz;
      lane_r.sat_re <= lane_nxt.sat_re;
      lane_r.sat_im <= lane_nxt.sat_im;
      lane_r.neg_re <= lane_nxt.neg_re;
      lane_r.neg_im <= lane_nxt.neg_im;
      lane_r.d      <= lane_nxt.d;
      lane_r.rem_re <= lane_nxt.rem_re;
      lane_r.rem_im <= lane_nxt.rem_im;
      lane_r.q_re   <= lane_nxt.q_re;
      lane_r.q_im   <= lane_nxt.q_im;
      lane_r.res_re <= lane_nxt.res_re;
      lane_r.res_im <= lane_nxt.res_im;
      lane_r.ov     <= lane_nxt.ov;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

FILE: design/cau_div_cell.sv
// one restoring divider cell: resolves one quotient bit for both parts, or the saturation flags in the top cell
`default_nettype none
module cau_div_cell import cau_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  lane_t     lane_i,
  output lane_t     lane_o
);

  lane_t       lane_r;
  lane_t       lane_nxt;
  logic [95:0] dsh;
  logic        ge_re, ge_im;

  always_comb begin
    dsh      = {32'b0, lane_i.d} << SHIFT;
    ge_re    = {32'b0, lane_i.rem_re} >= dsh;
    ge_im    = {32'b0, lane_i.rem_im} >= dsh;
    lane_nxt = lane_i;
    if (SHIFT >= QW) begin
      lane_nxt.sat_re = ge_re;
      lane_nxt.sat_im = ge_im;
    end else begin
      if (ge_re) begin
        lane_nxt.rem_re = lane_i.rem_re - dsh[NW-1:0];
        lane_nxt.q_re[SHIFT % QW] = 1'b1;
      end
      if (ge_im) begin
        lane_nxt.rem_im = lane_i.rem_im - dsh[NW-1:0];
        lane_nxt.q_im[SHIFT % QW] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.is_div <= lane_nxt.is_div;
      lane_r.dz     <= lane_nxt.dz;
      lane_r.sat_re <= lane_nxt.sat_re;
      lane_r.sat_im <= lane_nxt.sat_im;
      lane_r.neg_re <= lane_nxt.neg_re;
      lane_r.neg_im <= lane_nxt.neg_im;
      lane_r.d      <= lane_nxt.d;
      lane_r.rem_re <= lane_nxt.rem_re;
      lane_r.rem_im <= lane_nxt.rem_im;
      lane_r.q_re   <= lane_nxt.q_re;
      lane_r.q_im   <= lane_nxt.q_im;
      lane_r.res_re <= lane_nxt.res_re;
      lane_r.res_im <= lane_nxt.res_im;
      lane_r.ov     <= lane_nxt.ov;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

FILE: design/complex_arithmetic_unit.sv
// complex arithmetic unit top level: front stages, divider cell row, output register
// every op takes the same path from input transaction to result (2 front stages, 33 divider
//   cells, output register)
// throughput: one transaction per cycle; the whole pipeline holds while a result is stalled
// reset: synchronous active-low rst_n clears all valid bits; payload registers are not reset
`default_nettype none
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,   // op[2:0], a_re, a_im, b_re, b_im, zero pad
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [71:0]       out_tdata   // r_re, r_im, overflow, div_zero, zero pad
);

  logic  en;
  lane_t lanes [CELLS+1];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_op    (in_tdata[2:0]),
    .in_a_re  (in_tdata[34:3]),
    .in_a_im  (in_tdata[66:35]),
    .in_b_re  (in_tdata[98:67]),
    .in_b_im  (in_tdata[130:99]),
    .lane_o   (lanes[0])
  );

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    cau_div_cell #(.SHIFT(QW - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .lane_i (lanes[k]),
      .lane_o (lanes[k+1])
    );
  end

  lane_t          fin;
  logic [DW-1:0]  r_re_nxt, r_im_nxt;
  logic           ov_nxt, dz_nxt;
  logic           ov_re, ov_im;
  logic [DW-1:0]  v_re, v_im;
  logic           vld_r;
  logic [DW-1:0]  r_re_r, r_im_r;
  logic           ov_r, dz_r;

  always_comb begin
    fin   = lanes[CELLS];
    ov_re = fin.sat_re || (fin.neg_re ? (fin.q_re > {1'b1, {(QW-1){1'b0}}})
                                      : fin.q_re[QW-1]);
    ov_im = fin.sat_im || (fin.neg_im ? (fin.q_im > {1'b1, {(QW-1){1'b0}}})
                                      : fin.q_im[QW-1]);
    if (ov_re) begin
      v_re = fin.neg_re ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      v_re = fin.neg_re ? DW'(-fin.q_re) : fin.q_re;
    end
    if (ov_im) begin
      v_im = fin.neg_im ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      v_im = fin.neg_im ? DW'(-fin.q_im) : fin.q_im;
    end
    if (!fin.is_div) begin
      r_re_nxt = fin.res_re;
      r_im_nxt = fin.res_im;
      ov_nxt   = fin.ov;
      dz_nxt   = 1'b0;
    end else if (fin.dz) begin
      r_re_nxt = '0;
      r_im_nxt = '0;
      ov_nxt   = 1'b0;
      dz_nxt   = 1'b1;
    end else begin
      r_re_nxt = v_re;
      r_im_nxt = v_im;
      ov_nxt   = ov_re | ov_im;
      dz_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= fin.valid;
    end
    if (en) begin
      r_re_r <= r_re_nxt;
      r_im_r <= r_im_nxt;
      ov_r   <= ov_nxt;
      dz_r   <= dz_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {6'b0, dz_r, ov_r, r_im_r, r_re_r};

endmodule
`default_nettype wire

FILE: design/cau_checker.sv
// port-level checker for the complex arithmetic unit, bound to the top level
`default_nettype none
module cau_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [71:0]  out_tdata
);

  logic r_re_ext, r_im_ext;
  assign r_re_ext = (out_tdata[31:0] == 32'h7FFF_FFFF) || (out_tdata[31:0] == 32'h8000_0000);
  assign r_im_ext = (out_tdata[63:32] == 32'h7FFF_FFFF) || (out_tdata[63:32] == 32'h8000_0000);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result transaction changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65] |-> out_tdata[63:0] == 64'b0 && !out_tdata[64])
    else $error("divide by zero result not cleared");

  a_ov: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> r_re_ext || r_im_ext)
    else $error("overflow flag without saturated part");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready while result stalled");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

FILE: tb/complex_arithmetic_unit_tb.sv
// testbench for the complex arithmetic unit: directed and random operands checked against a predictor
`default_nettype none
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int FRAC = 16;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [31:0] b_im;
    logic [31:0] b_re;
    logic [31:0] a_im;
    logic [31:0] a_re;
    logic [2:0]  op;
  } operands_t;

  typedef struct packed {
    logic        dz;
    logic        ov;
    logic [31:0] r_im;
    logic [31:0] r_re;
  } answer_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;   // op, a_re, a_im, b_re, b_im, zero pad
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;  // r_re, r_im, overflow, div_zero, zero pad

  operands_t pending_q[$];
  answer_t   answers_q[$];
  int        idle_pct;
  int        stall_pct;
  int        errors;
  int        cycles;
  bit        busy;

  complex_arithmetic_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic logic signed [127:0] fxprod(logic signed [63:0] x, logic signed [63:0] y);
    logic signed [127:0] p;
    p = x * y;
    return p >>> FRAC;
  endfunction

  function automatic logic [31:0] clamp(logic signed [127:0] v, ref logic ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] fxdiv(logic signed [127:0] n, logic signed [127:0] d,
                                        ref logic ov);
    logic [127:0]        mag;
    logic [127:0]        q;
    logic signed [127:0] s;
    mag = (n < 0) ? -n : n;
    q = (mag << FRAC) / d;
    if (q > (128'd1 << 32)) q = 128'd1 << 32;
    s = (n < 0) ? -$signed(q) : $signed(q);
    return clamp(s, ov);
  endfunction

  function automatic answer_t complex_result(operands_t t);
    answer_t             r;
    logic signed [63:0]  ar, ai, br, bi;
    logic signed [127:0] d;
    logic                ov;
    ar = $signed(t.a_re); ai = $signed(t.a_im);
    br = $signed(t.b_re); bi = $signed(t.b_im);
    ov = 1'b0;
    r = '0;
    case (t.op)
      OP_ADD: begin
        r.r_re = clamp(ar + br, ov);
        r.r_im = clamp(ai + bi, ov);
      end
      OP_SUB: begin
        r.r_re = clamp(ar - br, ov);
        r.r_im = clamp(ai - bi, ov);
      end
      OP_MUL: begin
        r.r_re = clamp(fxprod(ar, br) - fxprod(ai, bi), ov);
        r.r_im = clamp(fxprod(ar, bi) + fxprod(ai, br), ov);
      end
      OP_DIV: begin
        d = fxprod(br, br) + fxprod(bi, bi);
        if (d == 0) r.dz = 1'b1;
        else begin
          r.r_re = fxdiv(fxprod(ar, br) + fxprod(ai, bi), d, ov);
          r.r_im = fxdiv(fxprod(ai, br) - fxprod(ar, bi), d, ov);
        end
      end
      OP_CONJ: begin
        r.r_re = clamp(ar, ov);
        r.r_im = clamp(-ai, ov);
      end
      OP_NEG: begin
        r.r_re = clamp(-ar, ov);
        r.r_im = clamp(-ai, ov);
      end
      OP_ABS2: r.r_re = clamp(fxprod(ar, ar) + fxprod(ai, ai), ov);
      default: ;
    endcase
    r.ov = ov;
    return r;
  endfunction

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 7) - 32'd3;
      3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      4: return $urandom_range(0, 255) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic operands_t rand_item();
    operands_t t;
    t.op = ($urandom_range(0, 29) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    t.a_re = rand_part(); t.a_im = rand_part();
    t.b_re = rand_part(); t.b_im = rand_part();
    if (t.op == OP_DIV && $urandom_range(0, 9) == 0) begin
      t.b_re = $urandom_range(0, 255); t.b_im = -$urandom_range(0, 255);
    end
    return t;
  endfunction

  task automatic queue_op(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                          logic [31:0] br, logic [31:0] bi);
    pending_q.push_back({bi, br, ai, ar, op});
  endtask

  task automatic run_phase(int idle, int stall, int n);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) pending_q.push_back(rand_item());
    while (pending_q.size() != 0 || busy || answers_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      busy <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) answers_q.push_back(complex_result(in_tdata[130:0]));
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_tdata <= {5'd0, pending_q.pop_front()};
          in_tvalid <= 1'b1;
          busy <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
          busy <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[65:0];
      if (answers_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = answers_q.pop_front();
        if (got.r_re !== want.r_re || got.r_im !== want.r_im ||
            got.ov !== want.ov || got.dz !== want.dz) begin
          errors++;
          $display("%0t: expected re %h im %h ov %b dz %b, actual re %h im %h ov %b dz %b",
                   $time, want.r_re, want.r_im, want.ov, want.dz,
                   got.r_re, got.r_im, got.ov, got.dz);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    busy = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // extremes, every op, divide by zero, tiny divisor, negate of minimum, unused code
    queue_op(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
    queue_op(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
    queue_op(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    queue_op(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
    queue_op(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    queue_op(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
    queue_op(OP_DIV, 32'h0001_0000, 32'h0, 32'h0000_00FF, 32'hFFFF_FF01);
    queue_op(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100, 32'h0);
    queue_op(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_op(OP_CONJ, 32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(OP_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    queue_op(OP_NEG, 32'h8000_0000, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_op(OP_NEG, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    queue_op(OP_ABS2, 32'h0003_0000, 32'hFFFC_0000, 32'hFFFF_FFFF, 32'h0);
    queue_op(OP_ABS2, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    queue_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(0, 0, 100);
    run_phase(55, 0, 100);
    run_phase(0, 55, 100);
    run_phase(38, 38, 100);
    repeat (60) @(posedge clk);
    if (errors == 0 && answers_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

FILE: complex_arithmetic_unit.f
design/cau_pkg.sv
design/cau_front.sv
design/cau_div_cell.sv
design/complex_arithmetic_unit.sv
design/cau_checker.sv
tb/complex_arithmetic_unit_tb.sv
